FILE: hw/rtl/variable_record_ring_log_defines.svh
// Assertion macros for the record ring log.
`ifndef VARIABLE_RECORD_RING_LOG_DEFINES_SVH
`define VARIABLE_RECORD_RING_LOG_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VRRL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrrl same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VRRL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrrl next-cycle check failed");

`endif

FILE: hw/rtl/vrrl_pkg.sv
// Shared types, codes and sizes of the record ring log.
package vrrl_pkg;

    localparam int DEPTH_WORDS = 4096;
    localparam int ADDR_W      = $clog2(DEPTH_WORDS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CAP_W       = 13;
    localparam int CAP_MIN     = 16;
    localparam int HW_W        = 30;   // header length in words: (33-bit sum) >> 3

    // item functions
    localparam logic [2:0] F_APPEND   = 3'd0;
    localparam logic [2:0] F_RD_START = 3'd1;
    localparam logic [2:0] F_RD_NEXT  = 3'd2;
    localparam logic [2:0] F_DROP     = 3'd3;
    localparam logic [2:0] F_CLEAR    = 3'd4;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LATCH    = 5'd1;
    localparam logic [4:0] OP_APP_WORD = 5'd2;
    localparam logic [4:0] OP_HDR_SHORT = 5'd3;
    localparam logic [4:0] OP_HDR_BIG  = 5'd4;
    localparam logic [4:0] OP_EV_RD    = 5'd5;
    localparam logic [4:0] OP_EV_STEP  = 5'd6;
    localparam logic [4:0] OP_RD_ABORT = 5'd7;
    localparam logic [4:0] OP_HDR_WR   = 5'd8;
    localparam logic [4:0] OP_RS_INIT  = 5'd9;
    localparam logic [4:0] OP_F_RDH    = 5'd10;
    localparam logic [4:0] OP_F_LAT    = 5'd11;
    localparam logic [4:0] OP_F_ADV    = 5'd12;
    localparam logic [4:0] OP_SET_END  = 5'd13;
    localparam logic [4:0] OP_RN_RD    = 5'd14;
    localparam logic [4:0] OP_RN_WORD  = 5'd15;
    localparam logic [4:0] OP_W_LOAD   = 5'd16;
    localparam logic [4:0] OP_RN_HIT   = 5'd17;
    localparam logic [4:0] OP_RN_MISS  = 5'd18;
    localparam logic [4:0] OP_DR_INIT  = 5'd19;
    localparam logic [4:0] OP_CP_INIT  = 5'd20;
    localparam logic [4:0] OP_CP_RD    = 5'd21;
    localparam logic [4:0] OP_CP_WR    = 5'd22;
    localparam logic [4:0] OP_CP_ADV   = 5'd23;
    localparam logic [4:0] OP_TL_INIT  = 5'd24;
    localparam logic [4:0] OP_DR_FIN   = 5'd25;
    localparam logic [4:0] OP_CLR      = 5'd26;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] data;
        logic        want_type;
        logic [31:0] key_db;
        logic [31:0] key_rel;
    } t_in;

    typedef struct packed {
        logic [63:0] rd_word;
        logic        rd_first;
        logic        rd_last;
        logic        rd_end;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       app_busy;
        logic       hdr_short;
        logic       hdr_big;
        logic       ev_need;
        logic       walk_done;
        logic       hit;
        logic       dst_eq;
        logic       copy_done;
        logic       tail_need;
        logic       rd_left_nz;
        logic       res_last;
    } t_stat;

endpackage

FILE: hw/rtl/variable_record_ring_log.sv
// Append words, short/oversized headers and clear are finished in the decode state.
// A header with eviction reads and frees each evicted record (one store read each), then
// is written. Reads and drop walk the ring record by record (header read, latch, test);
// drop copies each moved word with a read and a write, then advances past the record.
// One item at a time: busy stays high until the result strobe is scheduled.
// Sync active-low reset empties the ring; capacity resets to 4096. Store is not cleared.
// o_done marks the result for exactly one cycle; the receiver cannot stall.
`include "variable_record_ring_log_defines.svh"
module variable_record_ring_log (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  vrrl_pkg::t_in               i_item,
    input  logic                        i_cfg_we,
    input  logic [vrrl_pkg::CAP_W-1:0]  i_cfg_wdata,
    output vrrl_pkg::t_out              o_result,
    output logic                        o_done
);

    vrrl_pkg::t_cmd  cmd;
    vrrl_pkg::t_stat stat;

    // controller: one item per pass, issues one datapath op per cycle
    vrrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: single-port-write store with registered read, ring pointers
    vrrl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_done      (o_done)
    );

    `VRRL_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `VRRL_ASSERT_NXT(a_fin_done, cmd.fin, o_done)
    `VRRL_ASSERT_NXT(a_done_single, o_done, !o_done)
    `VRRL_ASSERT_IMP(a_status_noword, o_done && |o_result.status, o_result.rd_word == '0)

endmodule

FILE: hw/rtl/vrrl_ctrl.sv
// Sequencer of the record ring log: walks, copies, evictions.
module vrrl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  vrrl_pkg::t_stat i_stat,
    output vrrl_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_EV   = 4'd2;
    localparam logic [3:0] S_EVS  = 4'd3;
    localparam logic [3:0] S_HDR  = 4'd4;
    localparam logic [3:0] S_FH   = 4'd5;
    localparam logic [3:0] S_FL   = 4'd6;
    localparam logic [3:0] S_FS   = 4'd7;
    localparam logic [3:0] S_CR   = 4'd8;
    localparam logic [3:0] S_CW   = 4'd9;
    localparam logic [3:0] S_RNW  = 4'd10;
    localparam logic [3:0] S_RNC  = 4'd11;

    // what a walk is for
    localparam logic [2:0] M_START = 3'd0;
    localparam logic [2:0] M_NEXT  = 3'd1;
    localparam logic [2:0] M_LAST  = 3'd2;
    localparam logic [2:0] M_DROP  = 3'd3;
    localparam logic [2:0] M_TAIL  = 3'd4;

    logic [3:0] r_state, n_state;
    logic [2:0] r_mode, n_mode;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        o_cmd.op  = vrrl_pkg::OP_NONE;
        o_cmd.fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = vrrl_pkg::OP_LATCH;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (i_stat.func)
                    vrrl_pkg::F_APPEND: begin
                        if (i_stat.app_busy) begin
                            o_cmd.op = vrrl_pkg::OP_APP_WORD;  o_cmd.fin = 1'b1;
                        end else if (i_stat.hdr_short) begin
                            o_cmd.op = vrrl_pkg::OP_HDR_SHORT; o_cmd.fin = 1'b1;
                        end else if (i_stat.hdr_big) begin
                            o_cmd.op = vrrl_pkg::OP_HDR_BIG;   o_cmd.fin = 1'b1;
                        end else if (i_stat.ev_need) begin
                            n_state = S_EV;
                        end else begin
                            o_cmd.op = vrrl_pkg::OP_HDR_WR;    o_cmd.fin = 1'b1;
                        end
                    end
                    vrrl_pkg::F_RD_START: begin
                        o_cmd.op = vrrl_pkg::OP_RS_INIT;
                        n_mode   = M_START;
                        n_state  = S_FH;
                    end
                    vrrl_pkg::F_RD_NEXT: begin
                        if (i_stat.rd_left_nz) begin
                            o_cmd.op = vrrl_pkg::OP_RN_RD;
                            n_state  = S_RNW;
                        end else begin
                            o_cmd.op = vrrl_pkg::OP_W_LOAD;
                            n_mode   = M_NEXT;
                            n_state  = S_FH;
                        end
                    end
                    vrrl_pkg::F_DROP: begin
                        o_cmd.op = vrrl_pkg::OP_DR_INIT;
                        n_mode   = M_DROP;
                        n_state  = S_FH;
                    end
                    vrrl_pkg::F_CLEAR: begin
                        o_cmd.op = vrrl_pkg::OP_CLR; o_cmd.fin = 1'b1;
                    end
                    default: o_cmd.fin = 1'b1;
                endcase
            end
            S_EV: begin
                if (i_stat.ev_need) begin
                    o_cmd.op = vrrl_pkg::OP_EV_RD;
                    n_state  = S_EVS;
                end else begin
                    o_cmd.op = vrrl_pkg::OP_RD_ABORT;
                    n_state  = S_HDR;
                end
            end
            S_EVS: begin
                o_cmd.op = vrrl_pkg::OP_EV_STEP;
                n_state  = S_EV;
            end
            S_HDR: begin
                o_cmd.op  = vrrl_pkg::OP_HDR_WR;
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            S_FH: begin
                if (i_stat.walk_done) begin
                    n_state = S_IDLE;
                    case (r_mode)
                        M_NEXT: begin
                            o_cmd.op = vrrl_pkg::OP_RN_MISS; o_cmd.fin = 1'b1;
                        end
                        M_DROP: begin
                            if (i_stat.tail_need) begin
                                o_cmd.op = vrrl_pkg::OP_TL_INIT;
                                n_mode   = M_TAIL;
                                n_state  = S_CR;
                            end else begin
                                o_cmd.op = vrrl_pkg::OP_DR_FIN; o_cmd.fin = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.op = vrrl_pkg::OP_SET_END; o_cmd.fin = 1'b1;
                        end
                    endcase
                end else begin
                    o_cmd.op = vrrl_pkg::OP_F_RDH;
                    n_state  = S_FL;
                end
            end
            S_FL: begin
                o_cmd.op = vrrl_pkg::OP_F_LAT;
                n_state  = S_FS;
            end
            S_FS: begin
                n_state = S_FH;
                if (r_mode == M_DROP) begin
                    if (i_stat.hit)
                        o_cmd.op = vrrl_pkg::OP_F_ADV;
                    else if (i_stat.dst_eq)
                        o_cmd.op = vrrl_pkg::OP_CP_ADV;
                    else begin
                        o_cmd.op = vrrl_pkg::OP_CP_INIT;
                        n_state  = S_CR;
                    end
                end else if (i_stat.hit) begin
                    if (r_mode == M_NEXT) begin
                        o_cmd.op = vrrl_pkg::OP_RN_HIT;
                        n_state  = S_RNC;
                    end else begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    o_cmd.op = vrrl_pkg::OP_F_ADV;
                end
            end
            S_CR: begin
                if (i_stat.copy_done) begin
                    if (r_mode == M_TAIL) begin
                        o_cmd.op  = vrrl_pkg::OP_DR_FIN;
                        o_cmd.fin = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        o_cmd.op = vrrl_pkg::OP_CP_ADV;
                        n_state  = S_FH;
                    end
                end else begin
                    o_cmd.op = vrrl_pkg::OP_CP_RD;
                    n_state  = S_CW;
                end
            end
            S_CW: begin
                o_cmd.op = vrrl_pkg::OP_CP_WR;
                n_state  = S_CR;
            end
            S_RNW: begin
                o_cmd.op = vrrl_pkg::OP_RN_WORD;
                n_state  = S_RNC;
            end
            S_RNC: begin
                if (i_stat.res_last) begin
                    o_cmd.op = vrrl_pkg::OP_W_LOAD;
                    n_mode   = M_LAST;
                    n_state  = S_FH;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_START;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

FILE: hw/rtl/vrrl_dpath.sv
// Datapath of the record ring log: word store, pointers, walk registers.
module vrrl_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vrrl_pkg::t_cmd                i_cmd,
    input  vrrl_pkg::t_in                 i_item,
    input  logic                          i_cfg_we,
    input  logic [vrrl_pkg::CAP_W-1:0]    i_cfg_wdata,
    output vrrl_pkg::t_stat               o_stat,
    output vrrl_pkg::t_out                o_result,
    output logic                          o_done
);

    localparam int AW = vrrl_pkg::ADDR_W;
    localparam int CW = vrrl_pkg::CNT_W;
    localparam int HW = vrrl_pkg::HW_W;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                               input logic [CW-1:0] n,
                                               input logic [CW-1:0] c);
        logic [CW-1:0] s;
        s = {1'b0, p} + n;
        if (s >= c) s = s - c;
        return s[AW-1:0];
    endfunction

    function automatic logic [HW-1:0] hdr_words(input logic [31:0] len);
        logic [32:0] s;
        s = {1'b0, len} + 33'd7;
        return s[32:3];
    endfunction

    function automatic logic [CW-1:0] clamp_words(input logic [HW-1:0] w,
                                                  input logic [CW-1:0] room);
        logic [HW-1:0] r;
        r = (w == '0) ? HW'(1) : w;
        if (r > HW'(room)) return room;
        return r[CW-1:0];
    endfunction

    // ring state
    logic [vrrl_pkg::CAP_W-1:0] r_cap;
    logic [AW-1:0] r_oldest, r_free, r_rd_pos;
    logic [CW-1:0] r_used, r_app_left, r_app_w, r_rd_left, r_rd_walked;
    logic          r_app_disc;
    logic          r_done;

    // walk scratch and item
    vrrl_pkg::t_in  r_in;
    vrrl_pkg::t_out r_res;
    logic [63:0]    r_hdr;
    logic [AW-1:0]  r_wpos, r_dst;
    logic [CW-1:0]  r_wwalk, r_kept, r_cw, r_ci;

    // store
    logic [63:0]   r_mem [vrrl_pkg::DEPTH_WORDS];
    logic [63:0]   r_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wd;

    logic [CW-1:0] cap_now, cw_now, ew, big_left;
    logic [HW-1:0] in_w, in_w_m1;
    logic          rd_hit, dr_hit, two_plus;

    always_comb begin
        if (32'(r_cap) < 32'(vrrl_pkg::CAP_MIN))
            cap_now = CW'(vrrl_pkg::CAP_MIN);
        else if (32'(r_cap) > 32'(vrrl_pkg::DEPTH_WORDS))
            cap_now = CW'(vrrl_pkg::DEPTH_WORDS);
        else
            cap_now = CW'(r_cap);
    end

    assign in_w     = hdr_words(r_in.data[63:32]);
    assign in_w_m1  = in_w - HW'(1);
    assign big_left = (in_w_m1 > HW'(8191)) ? CW'(8191) : in_w_m1[CW-1:0];
    assign cw_now   = clamp_words(hdr_words(r_q[63:32]), r_used - r_wwalk);
    assign ew       = clamp_words(hdr_words(r_q[63:32]), r_used);

    // r_hdr holds the header, r_q the second word of the record under test
    assign two_plus = (r_cw >= CW'(2));
    assign rd_hit = (r_hdr[31:0] == {31'd0, r_in.want_type})
                    && (r_in.want_type || (two_plus && r_q[31:0] == r_in.key_db));
    assign dr_hit = (r_hdr[31:0] == 32'd0) && two_plus && (r_q[31:0] == r_in.key_db)
                    && ((r_in.key_rel == 32'd0) || (r_q[63:32] == r_in.key_rel));

    always_comb begin
        o_stat.func       = r_in.func;
        o_stat.app_busy   = (r_app_left != '0);
        o_stat.hdr_short  = (r_in.data[63:32] < 32'd8);
        o_stat.hdr_big    = (in_w > HW'(cap_now));
        o_stat.ev_need    = (HW'(cap_now - r_used) < in_w) && (r_used != '0);
        o_stat.walk_done  = (r_wwalk >= r_used);
        o_stat.hit        = (r_in.func == vrrl_pkg::F_DROP) ? dr_hit : rd_hit;
        o_stat.dst_eq     = (r_dst == r_wpos);
        o_stat.copy_done  = (r_ci == r_cw);
        o_stat.tail_need  = (r_app_left != '0) && !r_app_disc && (r_dst != r_free);
        o_stat.rd_left_nz = (r_rd_left != '0);
        o_stat.res_last   = r_res.rd_last;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_free;
        mem_wd = r_in.data;
        mem_ra = r_wpos;
        case (i_cmd.op)
            vrrl_pkg::OP_APP_WORD: begin
                mem_we = !r_app_disc;
                mem_wa = ring_add(r_free, r_app_w - r_app_left, cap_now);
            end
            vrrl_pkg::OP_HDR_WR: mem_we = 1'b1;
            vrrl_pkg::OP_CP_WR: begin
                mem_we = 1'b1;
                mem_wa = ring_add(r_dst, r_ci, cap_now);
                mem_wd = r_q;
            end
            vrrl_pkg::OP_EV_RD: mem_ra = r_oldest;
            vrrl_pkg::OP_F_LAT: mem_ra = ring_add(r_wpos, CW'(1), cap_now);
            vrrl_pkg::OP_CP_RD: mem_ra = ring_add(r_wpos, r_ci, cap_now);
            vrrl_pkg::OP_RN_RD: mem_ra = r_rd_pos;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_q <= r_mem[mem_ra];
    end

    // pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= vrrl_pkg::CAP_W'(vrrl_pkg::DEPTH_WORDS);
            r_oldest    <= '0;
            r_free      <= '0;
            r_used      <= '0;
            r_app_left  <= '0;
            r_app_w     <= '0;
            r_app_disc  <= 1'b0;
            r_rd_pos    <= '0;
            r_rd_left   <= '0;
            r_rd_walked <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
            unique case (i_cmd.op)
                vrrl_pkg::OP_APP_WORD: begin
                    r_app_left <= r_app_left - CW'(1);
                    if (r_app_left == CW'(1)) begin
                        if (r_app_disc) begin
                            r_app_disc <= 1'b0;
                        end else begin
                            r_free <= ring_add(r_free, r_app_w, cap_now);
                            r_used <= r_used + r_app_w;
                        end
                    end
                end
                vrrl_pkg::OP_HDR_BIG: begin
                    r_app_left <= big_left;
                    r_app_disc <= (big_left != '0);
                end
                vrrl_pkg::OP_EV_STEP: begin
                    r_oldest <= ring_add(r_oldest, ew, cap_now);
                    r_used   <= r_used - ew;
                end
                vrrl_pkg::OP_RD_ABORT: begin
                    r_rd_pos    <= r_free;
                    r_rd_walked <= r_used;
                    r_rd_left   <= '0;
                end
                vrrl_pkg::OP_HDR_WR: begin
                    if (in_w == HW'(1)) begin
                        r_free <= ring_add(r_free, CW'(1), cap_now);
                        r_used <= r_used + CW'(1);
                    end else begin
                        r_app_left <= in_w_m1[CW-1:0];
                        r_app_w    <= in_w[CW-1:0];
                        r_app_disc <= 1'b0;
                    end
                end
                vrrl_pkg::OP_RS_INIT: begin
                    r_rd_pos    <= r_oldest;
                    r_rd_walked <= '0;
                    r_rd_left   <= '0;
                end
                vrrl_pkg::OP_RN_WORD: begin
                    r_rd_left   <= r_rd_left - CW'(1);
                    r_rd_pos    <= ring_add(r_rd_pos, CW'(1), cap_now);
                    r_rd_walked <= r_rd_walked + CW'(1);
                end
                vrrl_pkg::OP_RN_HIT: begin
                    r_rd_left   <= r_cw - CW'(1);
                    r_rd_pos    <= ring_add(r_wpos, CW'(1), cap_now);
                    r_rd_walked <= r_wwalk + CW'(1);
                end
                vrrl_pkg::OP_RN_MISS: begin
                    r_rd_pos    <= r_wpos;
                    r_rd_walked <= r_wwalk;
                end
                vrrl_pkg::OP_DR_FIN: begin
                    r_free      <= r_dst;
                    r_used      <= r_kept;
                    r_rd_pos    <= r_dst;
                    r_rd_walked <= r_kept;
                    r_rd_left   <= '0;
                end
                vrrl_pkg::OP_CLR: begin
                    r_oldest    <= r_free;
                    r_used      <= '0;
                    r_rd_pos    <= r_free;
                    r_rd_walked <= '0;
                    r_rd_left   <= '0;
                end
                default: ;
            endcase
            if (i_cfg_we) begin
                r_cap       <= i_cfg_wdata;
                r_oldest    <= '0;
                r_free      <= '0;
                r_used      <= '0;
                r_app_left  <= '0;
                r_app_disc  <= 1'b0;
                r_rd_pos    <= '0;
                r_rd_left   <= '0;
                r_rd_walked <= '0;
            end
        end
    end

    // item, result and walk scratch
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            vrrl_pkg::OP_LATCH: begin
                r_in  <= i_item;
                r_res <= '0;
            end
            vrrl_pkg::OP_HDR_SHORT: r_res.status <= vrrl_pkg::ST_SHORT;
            vrrl_pkg::OP_HDR_BIG:   r_res.status <= vrrl_pkg::ST_TOO_LONG;
            vrrl_pkg::OP_RS_INIT, vrrl_pkg::OP_DR_INIT: begin
                r_wpos  <= r_oldest;
                r_wwalk <= '0;
                r_dst   <= r_oldest;
                r_kept  <= '0;
            end
            vrrl_pkg::OP_F_LAT: begin
                r_hdr <= r_q;
                r_cw  <= cw_now;
            end
            vrrl_pkg::OP_F_ADV: begin
                r_wpos  <= ring_add(r_wpos, r_cw, cap_now);
                r_wwalk <= r_wwalk + r_cw;
            end
            vrrl_pkg::OP_SET_END, vrrl_pkg::OP_RN_MISS: r_res.rd_end <= 1'b1;
            vrrl_pkg::OP_RN_WORD: begin
                r_res.rd_word <= r_q;
                r_res.rd_last <= (r_rd_left == CW'(1));
            end
            vrrl_pkg::OP_W_LOAD: begin
                r_wpos  <= r_rd_pos;
                r_wwalk <= r_rd_walked;
            end
            vrrl_pkg::OP_RN_HIT: begin
                r_res.rd_word  <= r_hdr;
                r_res.rd_first <= 1'b1;
                r_res.rd_last  <= (r_cw == CW'(1));
            end
            vrrl_pkg::OP_CP_INIT: r_ci <= '0;
            vrrl_pkg::OP_CP_WR:   r_ci <= r_ci + CW'(1);
            vrrl_pkg::OP_CP_ADV: begin
                r_dst   <= ring_add(r_dst, r_cw, cap_now);
                r_kept  <= r_kept + r_cw;
                r_wpos  <= ring_add(r_wpos, r_cw, cap_now);
                r_wwalk <= r_wwalk + r_cw;
            end
            vrrl_pkg::OP_TL_INIT: begin
                r_wpos <= r_free;
                r_cw   <= r_app_w;
                r_ci   <= '0;
            end
            default: ;
        endcase
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

FILE: dv/vrrl_scoreboard.sv
`timescale 1ns / 100ps
// Checker for the record ring log: tracks ring state, predicts each result and compares it.
module vrrl_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  vrrl_pkg::t_in               i_item,
    input  logic                        i_cfg_we,
    input  logic [vrrl_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  vrrl_pkg::t_out              o_result,
    input  logic                        o_done,
    output int                          o_fail_count,
    output int                          o_pending
);

    logic [63:0]    ring_store [0:vrrl_pkg::DEPTH_WORDS-1];
    int unsigned    cap_reg, head_pos, tail_pos, fill;
    int unsigned    app_left, rd_pos, rd_left, rd_walked;
    bit             app_drop;
    vrrl_pkg::t_out expected_q [$];
    int             fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic int unsigned cap_eff();
        if (cap_reg < vrrl_pkg::CAP_MIN) return vrrl_pkg::CAP_MIN;
        if (cap_reg > vrrl_pkg::DEPTH_WORDS) return vrrl_pkg::DEPTH_WORDS;
        return cap_reg;
    endfunction

    function automatic int unsigned ring_next(int unsigned p, longint unsigned n);
        return int'((longint'(p) + n) % cap_eff());
    endfunction

    function automatic longint unsigned rec_words(logic [63:0] h);
        return (longint'(h[63:32]) + 7) >> 3;
    endfunction

    function automatic int unsigned held_words(int unsigned pos, int unsigned room);
        longint unsigned w;
        w = rec_words(ring_store[pos]);
        if (w < 1) w = 1;
        if (w > room) w = room;
        return int'(w);
    endfunction

    function automatic bit db_hit(int unsigned pos, int unsigned w, logic [31:0] db,
                                  bit use_rel, logic [31:0] rel);
        logic [63:0] second;
        if (ring_store[pos][31:0] != 0 || w < 2) return 0;
        second = ring_store[ring_next(pos, 1)];
        if (second[31:0] != db) return 0;
        return !use_rel || second[63:32] == rel;
    endfunction

    function automatic bit seek(int unsigned pos, int unsigned walked, logic want,
                                logic [31:0] db, output int unsigned fpos,
                                output int unsigned fwalked, output int unsigned fw);
        int unsigned w;
        while (walked < fill) begin
            w = held_words(pos, fill - walked);
            if (ring_store[pos][31:0] == 32'(want) &&
                (want != 0 || db_hit(pos, w, db, 0, 0))) begin
                fpos = pos; fwalked = walked; fw = w;
                return 1;
            end
            pos = ring_next(pos, w);
            walked += w;
        end
        fpos = pos; fwalked = walked; fw = 0;
        return 0;
    endfunction

    function automatic void rd_abort();
        rd_pos = tail_pos; rd_walked = fill; rd_left = 0;
    endfunction

    function automatic void move_words(int unsigned dst, int unsigned src, int unsigned n);
        if (dst == src) return;
        for (int unsigned i = 0; i < n; i++)
            ring_store[ring_next(dst, i)] = ring_store[ring_next(src, i)];
    endfunction

    function automatic void empty_ring();
        head_pos = 0; tail_pos = 0; fill = 0; app_left = 0; app_drop = 0;
        rd_pos = 0; rd_left = 0; rd_walked = 0;
    endfunction

    function automatic logic [1:0] append_word(logic [63:0] word);
        int unsigned cap, w32, ew;
        longint unsigned w;
        cap = cap_eff();
        if (app_left != 0) begin
            if (app_drop) begin
                app_left--;
                if (app_left == 0) app_drop = 0;
            end else begin
                w32 = int'(rec_words(ring_store[tail_pos]));
                ring_store[ring_next(tail_pos, w32 - app_left)] = word;
                app_left--;
                if (app_left == 0) begin
                    tail_pos = ring_next(tail_pos, w32);
                    fill += w32;
                end
            end
            return vrrl_pkg::ST_OK;
        end
        if (word[63:32] < 8) return vrrl_pkg::ST_SHORT;
        w = rec_words(word);
        if (w > cap) begin
            app_left = (w - 1 > 8191) ? 8191 : int'(w - 1);
            app_drop = app_left != 0;
            return vrrl_pkg::ST_TOO_LONG;
        end
        if (cap - fill < w) begin
            // evict oldest records until the new one fits
            while (cap - fill < w && fill != 0) begin
                ew = held_words(head_pos, fill);
                head_pos = ring_next(head_pos, ew);
                fill -= ew;
            end
            rd_abort();
        end
        ring_store[tail_pos] = word;
        if (w == 1) begin
            tail_pos = ring_next(tail_pos, 1);
            fill++;
        end else begin
            app_left = int'(w) - 1;
            app_drop = 0;
        end
        return vrrl_pkg::ST_OK;
    endfunction

    function automatic void drop_matching(logic [31:0] db, logic [31:0] rel);
        int unsigned src, dst, walked, kept, w;
        src = head_pos; dst = head_pos; walked = 0; kept = 0;
        while (walked < fill) begin
            w = held_words(src, fill - walked);
            if (!db_hit(src, w, db, rel != 0, rel)) begin
                move_words(dst, src, w);
                dst = ring_next(dst, w);
                kept += w;
            end
            src = ring_next(src, w);
            walked += w;
        end
        // a record still being appended slides down with the rest
        if (app_left != 0 && !app_drop)
            move_words(dst, tail_pos, int'(rec_words(ring_store[tail_pos])));
        tail_pos = dst;
        fill = kept;
        rd_abort();
    endfunction

    function automatic vrrl_pkg::t_out predict_word(vrrl_pkg::t_in it);
        vrrl_pkg::t_out r;
        int unsigned p, wk, w;
        r = '0;
        case (it.func)
            vrrl_pkg::F_APPEND: r.status = append_word(it.data);
            vrrl_pkg::F_RD_START: begin
                rd_pos = head_pos; rd_walked = 0; rd_left = 0;
                r.rd_end = !seek(rd_pos, 0, it.want_type, it.key_db, p, wk, w);
            end
            vrrl_pkg::F_RD_NEXT: begin
                if (rd_left != 0) begin
                    r.rd_word = ring_store[rd_pos];
                    r.rd_last = rd_left == 1;
                    rd_left--;
                    rd_pos = ring_next(rd_pos, 1);
                    rd_walked++;
                end else if (seek(rd_pos, rd_walked, it.want_type, it.key_db, p, wk, w)) begin
                    r.rd_word  = ring_store[p];
                    r.rd_first = 1;
                    r.rd_last  = w == 1;
                    rd_left    = w - 1;
                    rd_pos     = ring_next(p, 1);
                    rd_walked  = wk + 1;
                end else begin
                    rd_pos = p; rd_walked = wk;
                    r.rd_end = 1;
                end
                if (r.rd_last)
                    r.rd_end = !seek(rd_pos, rd_walked, it.want_type, it.key_db, p, wk, w);
            end
            vrrl_pkg::F_DROP: drop_matching(it.key_db, it.key_rel);
            vrrl_pkg::F_CLEAR: begin
                head_pos = tail_pos;
                fill = 0;
                rd_abort();
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        for (int i = 0; i < vrrl_pkg::DEPTH_WORDS; i++) ring_store[i] = '0;
    end

    // Inputs change at the rising edge, so the falling edge sees stable values.
    always @(negedge i_clk) begin
        vrrl_pkg::t_out exp_w;
        if (!i_rst_n) begin
            cap_reg = vrrl_pkg::DEPTH_WORDS;
            empty_ring();
            expected_q.delete();
        end else begin
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (o_result.rd_word !== exp_w.rd_word) begin
                        $error("rd_word exp %h got %h", exp_w.rd_word, o_result.rd_word);
                        fails++;
                    end
                    if (o_result.rd_first !== exp_w.rd_first) begin
                        $error("rd_first exp %0d got %0d", exp_w.rd_first, o_result.rd_first);
                        fails++;
                    end
                    if (o_result.rd_last !== exp_w.rd_last) begin
                        $error("rd_last exp %0d got %0d", exp_w.rd_last, o_result.rd_last);
                        fails++;
                    end
                    if (o_result.rd_end !== exp_w.rd_end) begin
                        $error("rd_end exp %0d got %0d", exp_w.rd_end, o_result.rd_end);
                        fails++;
                    end
                    if (o_result.status !== exp_w.status) begin
                        $error("status exp %0d got %0d", exp_w.status, o_result.status);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
                empty_ring();
            end
            if (start && !busy)
                expected_q.push_back(predict_word(i_item));
        end
    end
endmodule

FILE: dv/tb_variable_record_ring_log.sv
`timescale 1ns / 100ps
// Testbench top for the record ring log: stimulus, watchdog and verdict.
module tb_variable_record_ring_log;

    localparam int STALL_LIMIT = 400000;  // cycles with no word moving

    logic                         i_clk = 0;
    logic                         i_rst_n = 0;
    logic                         start = 0;
    logic                         busy;
    vrrl_pkg::t_in                i_item = '0;
    logic                         i_cfg_we = 0;
    logic [vrrl_pkg::CAP_W-1:0]   i_cfg_wdata = '0;
    vrrl_pkg::t_out               o_result;
    logic                         o_done;
    int                           fail_count, pending;

    // falling-edge copies of the handshake, used at the next rising edge
    logic                         took_s = 0, done_s = 0;
    int                           stall_cnt = 0;

    int                           words_sent = 0, settings_run = 0, records_sent = 0;
    bit                           calm = 0;     // no-idle stretch
    int unsigned                  cap_now_tb = vrrl_pkg::DEPTH_WORDS;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    variable_record_ring_log dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_result(o_result), .o_done(o_done)
    );

    vrrl_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_result(o_result), .o_done(o_done),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk) begin
        took_s <= start && !busy;
        done_s <= o_done;
    end

    // Watchdog: give up when no word is accepted or returned for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || took_s || done_s) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Random idle cycles ahead of a word, about a quarter of the time, unless calm is set.
    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 25) begin
            start <= 0;
            @(posedge i_clk);
        end
    endtask

    // Drive one word and hold it until the block takes it; start stays up
    // until the next word, an idle cycle or a drain lowers it.
    task automatic push_word(vrrl_pkg::t_in it);
        idle_gap();
        start  <= 1;
        i_item <= it;
        do @(posedge i_clk); while (!took_s);
        words_sent++;
    endtask

    task automatic op_word(logic [2:0] f, logic [63:0] d, logic w,
                           logic [31:0] db, logic [31:0] rel);
        vrrl_pkg::t_in it;
        it.func = f; it.data = d; it.want_type = w; it.key_db = db; it.key_rel = rel;
        push_word(it);
    endtask

    task automatic append(logic [63:0] d);
        op_word(vrrl_pkg::F_APPEND, d, $urandom_range(1), $urandom, $urandom);
    endtask

    // Lower start, let every expected word come back, then idle before returning.
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [vrrl_pkg::CAP_W-1:0] v);
        drain();
        i_cfg_we    <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        cap_now_tb = (v < vrrl_pkg::CAP_MIN) ? vrrl_pkg::CAP_MIN :
                     (v > vrrl_pkg::DEPTH_WORDS) ? vrrl_pkg::DEPTH_WORDS : v;
        settings_run++;
    endtask

    function automatic logic [31:0] pick_db();
        return ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] pick_rel();
        return ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2) * 5;
    endfunction

    // One record: header, optional db/rel word for type 0, random payload.
    task automatic send_record();
        logic [31:0] typ, len;
        int unsigned nw, roll, maxw;
        roll = $urandom_range(99);
        typ  = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1);
        maxw = (cap_now_tb < 12) ? cap_now_tb : 12;
        if (roll < 5)
            len = $urandom_range(7);                         // short header
        else if (roll < 8 && cap_now_tb <= 64)
            len = (cap_now_tb + $urandom_range(1, 3)) * 8 - $urandom_range(7); // too long
        else
            len = $urandom_range(8, maxw * 8);
        append({len, typ});
        records_sent++;
        nw = (len + 7) / 8;
        if (len < 8) return;
        // a few records are cut short; the words that follow fill in the rest
        if ($urandom_range(19) == 0) nw = $urandom_range(1, nw);
        for (int unsigned i = 1; i < nw; i++) begin
            if (i == 1 && typ == 0)
                append({pick_rel(), pick_db()});
            else
                append({$urandom, $urandom});
        end
    endtask

    task automatic read_burst();
        logic w;
        logic [31:0] db;
        w  = $urandom_range(1);
        db = pick_db();
        op_word(vrrl_pkg::F_RD_START, {$urandom, $urandom}, w, db, $urandom);
        repeat ($urandom_range(1, 14)) begin
            // now and then a read-next item carries its own filter
            if ($urandom_range(7) == 0) begin
                w = $urandom_range(1);
                db = pick_db();
            end
            op_word(vrrl_pkg::F_RD_NEXT, {$urandom, $urandom}, w, db, $urandom);
        end
    endtask

    task automatic random_phase(int n_words);
        int unsigned r, target;
        target = words_sent + n_words;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 55)      send_record();
            else if (r < 80) read_burst();
            else if (r < 88) op_word(vrrl_pkg::F_DROP, {$urandom, $urandom},
                                     $urandom_range(1), pick_db(), pick_rel());
            else if (r < 91) op_word(vrrl_pkg::F_CLEAR, {$urandom, $urandom},
                                     $urandom_range(1), $urandom, $urandom);
            else if (r < 95) op_word(3'($urandom_range(5, 7)), {$urandom, $urandom},
                                     $urandom_range(1), $urandom, $urandom);
            else             append({$urandom, $urandom});   // stray word
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: smallest ring, every function and the odd headers.
        set_capacity(16);
        append({32'd16, 32'd1}); append(64'hFFFF_FFFF_FFFF_FFFF);    // checkpoint, 2 words
        append({32'd3, 32'd1});                                    // short header
        append({32'd0, 32'hFFFF_FFFF});                            // zero length
        append({32'd8, 32'd0});                                    // one-word type 0
        append({32'd24, 32'd0}); append({32'd5, 32'd2}); append(64'h0);  // db 2 rel 5
        op_word(vrrl_pkg::F_RD_START, 0, 0, 2, 0);
        op_word(vrrl_pkg::F_RD_NEXT, 0, 0, 2, 0);
        op_word(vrrl_pkg::F_RD_NEXT, 0, 0, 2, 0);
        op_word(vrrl_pkg::F_RD_NEXT, 0, 0, 2, 0);
        op_word(vrrl_pkg::F_RD_NEXT, 0, 0, 2, 0);                  // past the end
        op_word(vrrl_pkg::F_RD_START, 0, 1, 0, 0);
        op_word(vrrl_pkg::F_RD_NEXT, 0, 1, 0, 0);
        op_word(vrrl_pkg::F_DROP, 0, 0, 2, 6);                     // relation miss
        op_word(vrrl_pkg::F_DROP, 0, 0, 2, 0);                     // whole database
        append({32'd40, 32'd1});                                   // header with words pending
        op_word(vrrl_pkg::F_CLEAR, 0, 0, 0, 0);
        append(64'h1); append(64'h2); append(64'h3); append(64'h4); // pending record commits
        op_word(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        append({32'd17 * 8, 32'd1});                               // longer than the ring
        append({32'hFFFF_FFFF, 32'd0});                            // swallowed word
        set_capacity(0);                                           // write aborts the discard
        append({32'hFFFF_FFFF, 32'd1});                            // saturated discard
        set_capacity(8191);

        // Random phases over several ring sizes; one long stretch with no idling.
        random_phase(300);
        set_capacity(16);
        random_phase(250);
        drain();                                                   // sender holds off
        calm = 1;
        random_phase(150);
        calm = 0;
        set_capacity(17);
        random_phase(150);
        set_capacity(40);
        random_phase(200);
        set_capacity(4096);
        random_phase(150);
        set_capacity(1000);
        random_phase(100);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words (%0d record headers) across %0d ring sizes.",
                 words_sent, records_sent, settings_run);
        $display("Covered append, filtered reads, drops, clears, eviction and odd headers.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
